/* hdl/afm_pkg.sv */
// afm_pkg: widths and head-cell control/result structs for the adaptive
// frequency model. No dependencies.
`timescale 1ns / 1ps

package afm_pkg;

   // A stored count may briefly reach 16 bits plus a carry before halving.
   localparam int CNT_W = 17;
   // Running totals and cumulative sums.
   localparam int TOT_W = 17;
   // Result field widths.
   localparam int SYM_W = 8;
   localparam int RNG_W = 16;
   localparam int INC_W = 8;

   typedef struct packed {
      logic             halve;    // halving pass, not a symbol walk
      logic             dec;      // decode walk: search by target
      logic             found;    // symbol already seen in this walk
      logic             last;     // head holds the last symbol
      logic             key_hit;  // head holds the encode symbol
      logic [RNG_W-1:0] target;
      logic [TOT_W-1:0] low;      // sum of counts already passed
      logic [INC_W-1:0] inc;      // effective increment, never zero
   } head_ctl_type;

   typedef struct packed {
      logic             hit;      // this count belongs to the coded symbol
      logic [CNT_W-1:0] cnt_out;  // value written back into the ring
      logic [TOT_W-1:0] low_out;  // running low after this count
      logic [TOT_W-1:0] high;     // low plus this count
   } head_res_type;

endpackage

/* hdl/afm_cell.sv */
// afm_cell: one count of the ring; shifts toward the head when enabled.
// Depends on afm_pkg.
`timescale 1ns / 1ps

module afm_cell
   import afm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift,
   input  logic             clear,
   input  logic [CNT_W-1:0] d_in,
   output logic [CNT_W-1:0] q
);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   always_comb begin
      cnt_in = cnt_ff;
      if (clear) begin
         cnt_in = CNT_W'(1);
      end else if (shift) begin
         cnt_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= CNT_W'(1);
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign q = cnt_ff;

endmodule

/* hdl/afm_head.sv */
// afm_head: per-cycle arithmetic on the count at the head of the ring:
// cumulative sum, symbol match, increment and halving. Depends on afm_pkg.
`timescale 1ns / 1ps

module afm_head
   import afm_pkg::*;
(
   input  logic [CNT_W-1:0] cnt,
   input  head_ctl_type     ctl,
   output head_res_type     res
);

   logic [TOT_W-1:0] sum_lc;
   logic             over;
   logic [CNT_W-1:0] shr;
   logic [CNT_W-1:0] half;
   logic             hit;

   always_comb begin
      sum_lc = ctl.low + TOT_W'(cnt);
      over   = sum_lc > TOT_W'(ctl.target);
      shr    = cnt >> 1;
      half   = (shr == '0) ? CNT_W'(1) : shr;
      hit    = !ctl.halve && !ctl.found && (ctl.dec ? (over || ctl.last) : ctl.key_hit);

      res.hit = hit;
      if (ctl.halve) begin
         res.cnt_out = half;
      end else if (hit) begin
         res.cnt_out = cnt + CNT_W'(ctl.inc);
      end else begin
         res.cnt_out = cnt;
      end
      // low stops growing once the symbol is reached
      res.low_out = (!ctl.halve && !ctl.found && !hit) ? sum_lc : ctl.low;
      res.high    = sum_lc;
   end

endmodule

/* hdl/adaptive_frequency_model.sv */
// adaptive_frequency_model: top level. Ring of afm_cell counts, one afm_head
// at the ring's head, sequencer and registered result. Depends on afm_pkg.
`timescale 1ns / 1ps

// Adaptive symbol frequency model for an arithmetic coder. The per-symbol
// counts live in a ring of ALPHABET_SIZE cells that rotates one place per
// cycle past a single head unit while a walk or halving pass runs. An
// encode or decode item takes one pass: the head sums the counts below
// the symbol and bumps the symbol's count as it goes by. At the end of
// the pass its result is held in the pending result registers, and from
// there it moves into the output register. When the new total exceeds
// the limit, each halving round adds one more pass over the ring.
// Halving runs after the result is finished, so the result does not wait
// for it, and the next item can follow once the last round ends. One
// round is the usual case. More rounds are needed when the limit was
// lowered well below the built-up total, or when it sits close to
// ALPHABET_SIZE. A model reset, an unused op or a decode target at or
// above the total takes no pass: its result goes to the pending result
// registers as the item is taken and on into the output register. Results
// sit in an output register: the next item is taken once the previous
// result has moved there and the ring is back at rest. The configuration
// port is always ready; write it only while no item is in flight.
// Effective halving limit is max(total_limit, ALPHABET_SIZE+3).
module adaptive_frequency_model
   import afm_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   // item input
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_op,
   input  logic [SYM_W-1:0] req_symbol_in,
   input  logic [RNG_W-1:0] req_target,
   // result output
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SYM_W-1:0] rsp_symbol_out,
   output logic [RNG_W-1:0] rsp_range_low,
   output logic [RNG_W-1:0] rsp_range_high,
   output logic [RNG_W-1:0] rsp_range_total,
   output logic             rsp_bad_target,
   // register writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [RNG_W-1:0] csr_wdata
);

   localparam int IDX_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam int MIN_LIM = ALPHABET_SIZE + 3;

   localparam logic [1:0] OP_ENCODE = 2'd0;
   localparam logic [1:0] OP_DECODE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic REG_INCREMENT   = 1'b0;
   localparam logic REG_TOTAL_LIMIT = 1'b1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_WALK  = 2'd1;
   localparam logic [1:0] ST_HALVE = 2'd2;

   // ---------------- registers ----------------
   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;         // symbol currently at the head
   logic [IDX_W-1:0] key_ff, key_in;         // encode symbol
   logic [RNG_W-1:0] target_ff, target_in;   // decode target
   logic             dec_ff, dec_in;
   logic             found_ff, found_in;
   logic [TOT_W-1:0] low_ff, low_in;
   logic [TOT_W-1:0] sum_ff, sum_in;         // total rebuilt during halving
   logic [TOT_W-1:0] total_ff, total_in;
   logic [INC_W-1:0] increment_ff, increment_in;
   logic [RNG_W-1:0] limit_ff, limit_in;

   // finished result waiting for the output register
   logic             pend_ff, pend_in;
   logic [SYM_W-1:0] res_sym_ff, res_sym_in;
   logic [RNG_W-1:0] res_low_ff, res_low_in;
   logic [RNG_W-1:0] res_high_ff, res_high_in;
   logic [RNG_W-1:0] res_total_ff, res_total_in;
   logic             res_bad_ff, res_bad_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SYM_W-1:0] rsp_sym_ff, rsp_sym_in;
   logic [RNG_W-1:0] rsp_low_ff, rsp_low_in;
   logic [RNG_W-1:0] rsp_high_ff, rsp_high_in;
   logic [RNG_W-1:0] rsp_total_ff, rsp_total_in;
   logic             rsp_bad_ff, rsp_bad_in;

   // ---------------- ring of counts ----------------
   logic [CNT_W-1:0] cnt_q [ALPHABET_SIZE];
   logic             ring_shift;
   logic             ring_clear;
   head_ctl_type     head_ctl;
   head_res_type     head_res;

   genvar gi;
   generate
      for (gi = 0; gi < ALPHABET_SIZE; gi++) begin : g_cell
         logic [CNT_W-1:0] d_next;
         if (gi == ALPHABET_SIZE - 1) begin : g_tail
            assign d_next = head_res.cnt_out;   // head feeds back into the tail
         end else begin : g_mid
            assign d_next = cnt_q[gi+1];
         end
         afm_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (ring_shift),
            .clear (ring_clear),
            .d_in  (d_next),
            .q     (cnt_q[gi])
         );
      end
   endgenerate

   // ---------------- head ----------------
   logic [INC_W-1:0] inc_eff;
   logic [TOT_W-1:0] lim_eff;
   logic             at_last;

   assign inc_eff = (increment_ff == '0) ? INC_W'(1) : increment_ff;
   assign lim_eff = (limit_ff < RNG_W'(MIN_LIM)) ? TOT_W'(MIN_LIM) : TOT_W'(limit_ff);
   assign at_last = idx_ff == IDX_W'(ALPHABET_SIZE - 1);

   always_comb begin
      head_ctl.halve   = state_ff == ST_HALVE;
      head_ctl.dec     = dec_ff;
      head_ctl.found   = found_ff;
      head_ctl.last    = at_last;
      head_ctl.key_hit = idx_ff == key_ff;
      head_ctl.target  = target_ff;
      head_ctl.low     = low_ff;
      head_ctl.inc     = inc_eff;
   end

   afm_head u_head (
      .cnt (cnt_q[0]),
      .ctl (head_ctl),
      .res (head_res)
   );

   // ---------------- control ----------------
   logic             req_acc;
   logic [TOT_W-1:0] tot_bump;
   logic [TOT_W-1:0] sum_next;

   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign tot_bump  = total_ff + TOT_W'(inc_eff);
   assign sum_next  = sum_ff + TOT_W'(head_res.cnt_out);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      target_in    = target_ff;
      dec_in       = dec_ff;
      found_in     = found_ff;
      low_in       = low_ff;
      sum_in       = sum_ff;
      total_in     = total_ff;
      increment_in = increment_ff;
      limit_in     = limit_ff;
      pend_in      = pend_ff;
      res_sym_in   = res_sym_ff;
      res_low_in   = res_low_ff;
      res_high_in  = res_high_ff;
      res_total_in = res_total_ff;
      res_bad_in   = res_bad_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_low_in   = rsp_low_ff;
      rsp_high_in  = rsp_high_ff;
      rsp_total_in = rsp_total_ff;
      rsp_bad_in   = rsp_bad_ff;
      ring_shift   = 1'b0;
      ring_clear   = 1'b0;

      // register writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_INCREMENT:   increment_in = csr_wdata[INC_W-1:0];
            REG_TOTAL_LIMIT: limit_in     = csr_wdata;
            default:         ;
         endcase
      end

      // move a finished result into the output register
      if (pend_ff && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_in = 1'b1;
         rsp_sym_in   = res_sym_ff;
         rsp_low_in   = res_low_ff;
         rsp_high_in  = res_high_ff;
         rsp_total_in = res_total_ff;
         rsp_bad_in   = res_bad_ff;
         pend_in      = 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               res_sym_in   = '0;
               res_low_in   = '0;
               res_high_in  = '0;
               res_total_in = '0;
               res_bad_in   = 1'b0;
               idx_in       = '0;
               low_in       = '0;
               found_in     = 1'b0;
               case (req_op)
                  OP_ENCODE: begin
                     // out-of-alphabet symbols clamp to the last one
                     if (32'(req_symbol_in) >= ALPHABET_SIZE) begin
                        key_in = IDX_W'(ALPHABET_SIZE - 1);
                     end else begin
                        key_in = IDX_W'(req_symbol_in);
                     end
                     dec_in       = 1'b0;
                     res_total_in = total_ff[RNG_W-1:0];
                     state_in     = ST_WALK;
                  end
                  OP_DECODE: begin
                     if (TOT_W'(req_target) >= total_ff) begin
                        res_bad_in = 1'b1;
                        pend_in    = 1'b1;
                     end else begin
                        target_in    = req_target;
                        dec_in       = 1'b1;
                        res_total_in = total_ff[RNG_W-1:0];
                        state_in     = ST_WALK;
                     end
                  end
                  OP_CLEAR: begin
                     ring_clear = 1'b1;
                     total_in   = TOT_W'(ALPHABET_SIZE);
                     pend_in    = 1'b1;
                  end
                  default: begin
                     pend_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            ring_shift = 1'b1;
            low_in     = head_res.low_out;
            idx_in     = at_last ? '0 : idx_ff + IDX_W'(1);
            if (head_res.hit) begin
               found_in    = 1'b1;
               res_sym_in  = SYM_W'(idx_ff);
               res_low_in  = low_ff[RNG_W-1:0];
               res_high_in = head_res.high[RNG_W-1:0];
            end
            if (at_last) begin
               pend_in  = 1'b1;
               total_in = tot_bump;
               sum_in   = '0;
               state_in = (tot_bump > lim_eff) ? ST_HALVE : ST_IDLE;
            end
         end
         ST_HALVE: begin
            ring_shift = 1'b1;
            sum_in     = sum_next;
            idx_in     = at_last ? '0 : idx_ff + IDX_W'(1);
            if (at_last) begin
               // another round if the halved total still exceeds the limit
               total_in = sum_next;
               sum_in   = '0;
               state_in = (sum_next > lim_eff) ? ST_HALVE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         total_ff     <= TOT_W'(ALPHABET_SIZE);
         increment_ff <= INC_W'(1);
         limit_ff     <= RNG_W'(16383);
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         increment_ff <= increment_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      target_ff    <= target_in;
      dec_ff       <= dec_in;
      low_ff       <= low_in;
      sum_ff       <= sum_in;
      res_sym_ff   <= res_sym_in;
      res_low_ff   <= res_low_in;
      res_high_ff  <= res_high_in;
      res_total_ff <= res_total_in;
      res_bad_ff   <= res_bad_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_total_ff <= rsp_total_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_symbol_out  = rsp_sym_ff;
   assign rsp_range_low   = rsp_low_ff;
   assign rsp_range_high  = rsp_high_ff;
   assign rsp_range_total = rsp_total_ff;
   assign rsp_bad_target  = rsp_bad_ff;

endmodule

/* dv/afm_tb_pkg.sv */
// afm_tb_pkg: op codes, register indexes and the result record shared by the
// adaptive frequency model testbench and its checker. Depends on afm_pkg.
`timescale 1ns / 1ps

package afm_tb_pkg;

   import afm_pkg::*;

   typedef enum logic [1:0] {
      OP_ENCODE = 2'd0,
      OP_DECODE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } model_op_type;

   localparam logic REG_INCREMENT   = 1'b0;
   localparam logic REG_TOTAL_LIMIT = 1'b1;

   // Register values after reset.
   localparam logic [INC_W-1:0] INCREMENT_AT_RESET   = 8'd1;
   localparam logic [RNG_W-1:0] TOTAL_LIMIT_AT_RESET = 16'd16383;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic [RNG_W-1:0] low;
      logic [RNG_W-1:0] high;
      logic [RNG_W-1:0] total;
      logic             bad;
   } coding_result_type;

endpackage

/* dv/adaptive_frequency_model_checker.sv */
// adaptive_frequency_model_checker: keeps its own count store, predicts the
// result of every accepted item and compares. Depends on afm_pkg, afm_tb_pkg.
`timescale 1ns / 1ps

module adaptive_frequency_model_checker
   import afm_pkg::*;
   import afm_tb_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [1:0]       req_op,
   input  logic [SYM_W-1:0] req_symbol_in,
   input  logic [RNG_W-1:0] req_target,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [SYM_W-1:0] rsp_symbol_out,
   input  logic [RNG_W-1:0] rsp_range_low,
   input  logic [RNG_W-1:0] rsp_range_high,
   input  logic [RNG_W-1:0] rsp_range_total,
   input  logic             rsp_bad_target,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic             csr_index,
   input  logic [RNG_W-1:0] csr_wdata,
   output int               mismatch_count,
   output int               open_count,
   output logic [TOT_W-1:0] model_total
);

   logic [CNT_W-1:0]  sym_count [ALPHABET_SIZE];
   logic [TOT_W-1:0]  count_total;
   logic [INC_W-1:0]  increment_reg;
   logic [RNG_W-1:0]  total_limit_reg;
   coding_result_type expected_codes [$];
   int                mismatches;

   function automatic void clear_counts();
      int i;
      for (i = 0; i < ALPHABET_SIZE; i++)
         sym_count[i] = CNT_W'(1);
      count_total = TOT_W'(ALPHABET_SIZE);
   endfunction

   // Halve every count, floor at one, and re-form the total.
   function automatic void halve_counts();
      int          i;
      int unsigned sum;
      sum = 0;
      for (i = 0; i < ALPHABET_SIZE; i++) begin
         sym_count[i] = sym_count[i] >> 1;
         if (sym_count[i] == '0)
            sym_count[i] = CNT_W'(1);
         sum = sum + 32'(sym_count[i]);
      end
      count_total = TOT_W'(sum);
   endfunction

   function automatic void bump_count(int unsigned sym);
      int unsigned step;
      int unsigned lim;
      step = (increment_reg == '0) ? 32'd1 : 32'(increment_reg);
      lim  = 32'(total_limit_reg);
      if (lim < ALPHABET_SIZE + 3)
         lim = ALPHABET_SIZE + 3;
      sym_count[sym] = sym_count[sym] + CNT_W'(step);
      count_total    = count_total + TOT_W'(step);
      while (count_total > TOT_W'(lim))
         halve_counts();
   endfunction

   function automatic coding_result_type code_item(model_op_type op,
                                                   logic [SYM_W-1:0] sym_in,
                                                   logic [RNG_W-1:0] tgt);
      coding_result_type r;
      int unsigned       sym;
      int unsigned       low;
      int unsigned       high;
      int unsigned       t;
      int unsigned       i;
      r   = '0;
      low = 0;
      case (op)
         OP_ENCODE: begin
            sym = 32'(sym_in);
            if (sym >= ALPHABET_SIZE)
               sym = ALPHABET_SIZE - 1;
            for (i = 0; i < sym; i++)
               low = low + 32'(sym_count[i]);
            high     = low + 32'(sym_count[sym]);
            r.symbol = sym[SYM_W-1:0];
            r.low    = low[RNG_W-1:0];
            r.high   = high[RNG_W-1:0];
            r.total  = count_total[RNG_W-1:0];
            bump_count(sym);
         end
         OP_DECODE: begin
            t = 32'(tgt);
            if (t >= 32'(count_total)) begin
               r.bad = 1'b1;
            end else begin
               r.total = count_total[RNG_W-1:0];
               sym     = 0;
               while (sym < ALPHABET_SIZE - 1 && t >= 32'(sym_count[sym])) begin
                  low = low + 32'(sym_count[sym]);
                  t   = t - 32'(sym_count[sym]);
                  sym++;
               end
               high     = low + 32'(sym_count[sym]);
               r.symbol = sym[SYM_W-1:0];
               r.low    = low[RNG_W-1:0];
               r.high   = high[RNG_W-1:0];
               bump_count(sym);
            end
         end
         OP_CLEAR: clear_counts();
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      coding_result_type seen;
      coding_result_type want;
      if (reset) begin
         increment_reg   = INCREMENT_AT_RESET;
         total_limit_reg = TOTAL_LIMIT_AT_RESET;
         clear_counts();
         expected_codes.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_INCREMENT)
               increment_reg = csr_wdata[INC_W-1:0];
            else
               total_limit_reg = csr_wdata;
         end
         // Results first, so an item taken at this same edge is never matched.
         if (rsp_valid && !rsp_stall) begin
            seen.symbol = rsp_symbol_out;
            seen.low    = rsp_range_low;
            seen.high   = rsp_range_high;
            seen.total  = rsp_range_total;
            seen.bad    = rsp_bad_target;
            if (expected_codes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR %0t: unexpected result sym %0d low %0d high %0d total %0d bad %0b",
                           $time, seen.symbol, seen.low, seen.high, seen.total, seen.bad);
            end else begin
               want = expected_codes.pop_front();
               if (seen.symbol != want.symbol || seen.low != want.low ||
                   seen.high != want.high || seen.total != want.total ||
                   seen.bad != want.bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("ERROR %0t: expected sym %0d low %0d high %0d total %0d bad %0b",
                              $time, want.symbol, want.low, want.high, want.total, want.bad);
                     $display("             got sym %0d low %0d high %0d total %0d bad %0b",
                              seen.symbol, seen.low, seen.high, seen.total, seen.bad);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            expected_codes.push_back(code_item(model_op_type'(req_op), req_symbol_in,
                                               req_target));
      end
      mismatch_count <= mismatches;
      open_count     <= expected_codes.size();
      model_total    <= count_total;
   end

endmodule

/* dv/adaptive_frequency_model_tb.sv */
// adaptive_frequency_model_tb: stimulus, handshake pacing and verdict for the
// adaptive frequency model. Depends on afm_pkg, afm_tb_pkg and the checker.
`timescale 1ns / 1ps

module adaptive_frequency_model_tb;

   import afm_pkg::*;
   import afm_tb_pkg::*;

   localparam int SIZE = 256;
   // Worst item: one walk plus up to ~16 halving passes when a large count
   // meets a limit near SIZE+3. Config writes wait this long after the last
   // result so no halving pass is still running.
   localparam int DRAIN_CYCLES   = 20 * SIZE;
   // Receiver hold-off, long enough for the block to back up into its input.
   localparam int HOLD_CYCLES    = 12 * SIZE;
   // No handshake at all for this long means the block is hung.
   localparam int WATCHDOG_LIMIT = 60000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [1:0]       req_op;
   logic [SYM_W-1:0] req_symbol_in;
   logic [RNG_W-1:0] req_target;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [SYM_W-1:0] rsp_symbol_out;
   logic [RNG_W-1:0] rsp_range_low;
   logic [RNG_W-1:0] rsp_range_high;
   logic [RNG_W-1:0] rsp_range_total;
   logic             rsp_bad_target;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_index;
   logic [RNG_W-1:0] csr_wdata;

   int               mismatch_count;
   int               open_count;
   logic [TOT_W-1:0] model_total;

   int items_sent;
   int results_seen;
   int quiet_cycles;
   int n_encode, n_decode, n_past_total, n_clear, n_unused, n_settings;
   bit steady_flow;    // both sides stop idling while set
   bit rsp_held;

   adaptive_frequency_model #(.ALPHABET_SIZE(SIZE)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_symbol_in   (req_symbol_in),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol_out  (rsp_symbol_out),
      .rsp_range_low   (rsp_range_low),
      .rsp_range_high  (rsp_range_high),
      .rsp_range_total (rsp_range_total),
      .rsp_bad_target  (rsp_bad_target),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   adaptive_frequency_model_checker #(.ALPHABET_SIZE(SIZE)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_symbol_in   (req_symbol_in),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol_out  (rsp_symbol_out),
      .rsp_range_low   (rsp_range_low),
      .rsp_range_high  (rsp_range_high),
      .rsp_range_total (rsp_range_total),
      .rsp_bad_target  (rsp_bad_target),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .open_count      (open_count),
      .model_total     (model_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one item and hold it until taken. Valid is left high on return:
   // the caller either offers the next item in the same step or drops it.
   // Before some items, unless steady_flow is set, valid drops for a random gap.
   task automatic send_item(input model_op_type op, input logic [SYM_W-1:0] sym,
                            input logic [RNG_W-1:0] tgt);
      if (!steady_flow && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2 * SIZE)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_symbol_in <= sym;
      req_target    <= tgt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      case (op)
         OP_ENCODE: n_encode++;
         OP_DECODE: begin
            n_decode++;
            if (tgt >= model_total)
               n_past_total++;
         end
         OP_CLEAR:  n_clear++;
         default:   n_unused++;
      endcase
   endtask

   // Drop valid and wait for every outstanding result; afterwards the
   // predicted total is current, so exact boundary targets can be formed.
   task automatic wait_results();
      req_valid <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
   endtask

   // Full quiesce: results in, then let any trailing halving pass finish.
   task automatic quiesce();
      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Both registers, back to back; valid drops only after the second write.
   task automatic set_registers(input logic [INC_W-1:0] inc,
                                input logic [RNG_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_index <= REG_INCREMENT;
      csr_wdata <= {8'($urandom), inc};    // upper byte is don't-care
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= REG_TOTAL_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // Mostly coder-like traffic: encodes leaning on one hot symbol (to grow a
   // large count) and decodes with targets inside the total; the rest is
   // wild targets, targets exactly at the total, unused ops and clears.
   // The total used for targets may trail by one item, which can move an
   // occasional decode to the other side of the total.
   task automatic run_coding(input int n, input logic [SYM_W-1:0] hot);
      int k;
      int pick;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 45)
            send_item(OP_ENCODE, $urandom_range(1) ? hot : 8'($urandom), 16'($urandom));
         else if (pick < 88)
            send_item(OP_DECODE, 8'($urandom), 16'($urandom_range(0, model_total - 1)));
         else if (pick < 94)
            send_item(OP_DECODE, 8'($urandom), 16'($urandom));
         else if (pick < 96)
            send_item(OP_DECODE, 8'($urandom), model_total[RNG_W-1:0]);
         else if (pick < 99)
            send_item(OP_UNUSED, 8'($urandom), 16'($urandom));
         else
            send_item(OP_CLEAR, 8'($urandom), 16'($urandom));
      end
   endtask

   // Result side: random stalls, no stalls during the steady stretch, and
   // one long hold-off once traffic is going so the input backs up.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            results_seen++;
         if (!rsp_held && results_seen >= 60) begin
            rsp_held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !steady_flow && ($urandom_range(99) < 32);
         end
      end
   end

   // Watchdog: any handshake on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TIMEOUT: no handshake for %0d cycles, %0d items sent, %0d results",
                  WATCHDOG_LIMIT, items_sent, results_seen);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_ENCODE;
      req_symbol_in = '0;
      req_target    = '0;
      csr_valid     = 1'b0;
      csr_index     = REG_INCREMENT;
      csr_wdata     = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed, at reset register values: alphabet ends, target edges,
      // out-of-range targets, unused op and model clears.
      send_item(OP_ENCODE, 8'd0, 16'hFFFF);
      send_item(OP_ENCODE, 8'd255, 16'h0000);
      send_item(OP_ENCODE, 8'd128, 16'h0000);
      send_item(OP_DECODE, 8'hFF, 16'd0);
      wait_results();
      send_item(OP_DECODE, 8'h00, model_total[RNG_W-1:0] - 16'd1);    // last symbol
      wait_results();
      send_item(OP_DECODE, 8'h00, model_total[RNG_W-1:0]);            // exactly at total
      send_item(OP_DECODE, 8'h00, 16'hFFFF);
      send_item(OP_DECODE, 8'h00, 16'h0101);
      send_item(OP_UNUSED, 8'hFF, 16'hFFFF);
      send_item(OP_CLEAR, 8'hAA, 16'h5555);
      send_item(OP_DECODE, 8'h00, 16'd255);                           // top of fresh model
      send_item(OP_DECODE, 8'h00, 16'd256);                           // just past it
      send_item(OP_ENCODE, 8'hAA, 16'h5555);
      send_item(OP_ENCODE, 8'h55, 16'hAAAA);
      send_item(OP_DECODE, 8'h55, 16'h00AA);
      send_item(OP_CLEAR, 8'h55, 16'hAAAA);
      send_item(OP_ENCODE, 8'h7F, 16'h8000);

      // Largest increment and limit: one symbol's count climbs high.
      quiesce();
      set_registers(8'd255, 16'hFFFF);
      run_coding(150, 8'($urandom));

      // Limit dropped below the built-up total: halving waits for the next
      // update, then needs many rounds.
      quiesce();
      set_registers(8'd200, 16'd300);
      run_coding(40, 8'($urandom));

      // Zero increment and zero limit, with no idling on either side.
      quiesce();
      steady_flow = 1'b1;
      set_registers(8'd0, 16'd0);
      run_coding(100, 8'($urandom));
      steady_flow = 1'b0;

      quiesce();
      set_registers(8'($urandom_range(1, 255)), 16'($urandom));
      run_coding(150, 8'($urandom));

      // Limit close to the floor: frequent multi-round halving.
      quiesce();
      set_registers(8'($urandom_range(1, 255)), 16'($urandom_range(SIZE + 3, 600)));
      run_coding(150, 8'($urandom));

      quiesce();

      $display("Sent %0d items: %0d encodes, %0d decodes (%0d aimed at or past the total),",
               items_sent, n_encode, n_decode, n_past_total);
      $display("%0d clears, %0d unused ops, over %0d register settings; %0d results checked.",
               n_clear, n_unused, n_settings, results_seen);
      if (mismatch_count == 0 && open_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatch_count, open_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/afm_pkg.sv
hdl/afm_cell.sv
hdl/afm_head.sv
hdl/adaptive_frequency_model.sv
dv/afm_tb_pkg.sv
dv/adaptive_frequency_model_checker.sv
dv/adaptive_frequency_model_tb.sv
